/* hw/rtl/fmprc_pkg.sv */
// ============================================================================
// First-match packet rule classifier package
// Word types, operation and cause codes, and protocol constants.
// ============================================================================
`default_nettype none

package fmprc_pkg;

    localparam int FMPRC_RULE_SLOTS = 64;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_CLASSIFY = 2'd2;

    localparam logic [2:0] CAUSE_HIT        = 3'd0;
    localparam logic [2:0] CAUSE_XMAS       = 3'd1;
    localparam logic [2:0] CAUSE_IRRELEVANT = 3'd2;
    localparam logic [2:0] CAUSE_DEFAULT    = 3'd3;
    localparam logic [2:0] CAUSE_NONE       = 3'd4;

    localparam logic [8:0] PROTO_ICMP = 9'd1;
    localparam logic [8:0] PROTO_TCP  = 9'd6;
    localparam logic [8:0] PROTO_UDP  = 9'd17;
    localparam logic [8:0] PROTO_ANY  = 9'd256;

    localparam logic [3:0] IP_VERSION_6 = 4'd6;
    localparam logic [2:0] XMAS_FLAGS   = 3'b111;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [5:0]  src_prefix_len;
        logic [5:0]  dst_prefix_len;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [8:0]  protocol;
        logic [1:0]  ack_mode;
        logic [2:0]  tcp_flags;
        logic [3:0]  ip_version;
        logic        rule_action;
    } in_word_t;

    typedef struct packed {
        logic       verdict;
        logic [2:0] decision_cause;
        logic [5:0] hit_index;
        logic       table_full;
        logic [6:0] stored_count;
    } out_word_t;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } rule_addr_t;

    typedef struct packed {
        logic        action;
        logic [1:0]  ack_mode;
        logic [8:0]  protocol;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [5:0]  dst_prefix_len;
        logic [5:0]  src_prefix_len;
    } rule_fields_t;

endpackage

`default_nettype wire

/* hw/rtl/fmprc_rule_match.sv */
// ============================================================================
// Rule match
// Compares one stored rule against the packet held for classification.
// ============================================================================
`default_nettype none

module fmprc_rule_match
    import fmprc_pkg::*;
(
    input  wire in_word_t     pkt,
    input  wire rule_addr_t   rule_addr,
    input  wire rule_fields_t rule_fields,
    output logic              match
);

    logic [31:0] src_mask;
    logic [31:0] dst_mask;
    logic        src_ok;
    logic        dst_ok;
    logic        proto_ok;
    logic        sport_ok;
    logic        dport_ok;
    logic        ack_ok;

    // A prefix length of zero gives an empty mask, 32 and above a full one.
    assign src_mask = ~(32'hFFFF_FFFF >> rule_fields.src_prefix_len);
    assign dst_mask = ~(32'hFFFF_FFFF >> rule_fields.dst_prefix_len);

    assign src_ok   = (rule_addr.src_addr == 32'd0) ||
                      ((pkt.src_addr & src_mask) == (rule_addr.src_addr & src_mask));
    assign dst_ok   = (rule_addr.dst_addr == 32'd0) ||
                      ((pkt.dst_addr & dst_mask) == (rule_addr.dst_addr & dst_mask));
    assign proto_ok = (rule_fields.protocol == PROTO_ANY) ||
                      (rule_fields.protocol == pkt.protocol);
    assign sport_ok = (rule_fields.sport == 16'd0) ||
                      (rule_fields.sport == pkt.sport);
    assign dport_ok = (rule_fields.dport == 16'd0) ||
                      (rule_fields.dport == pkt.dport);
    assign ack_ok   = rule_fields.ack_mode[1] ||
                      (rule_fields.ack_mode[0] == pkt.ack_mode[0]);

    assign match = src_ok && dst_ok && proto_ok && sport_ok && dport_ok && ack_ok;

endmodule

`default_nettype wire

/* hw/rtl/first_match_packet_rule_classifier.sv */
// ============================================================================
// First-match packet rule classifier
// Rule table in two synchronous memories, scanned in insertion order.
// ============================================================================
//  channel   direction  handshake          word
//  s_        in         s_valid / s_ready  in_word_t  (clear, add, classify)
//  m_        out        m_valid / m_ready  out_word_t (one per input word)
//
//  Clear, add and classify words decided by the header pass from idle to
//  the emit state. A classify that scans the table does one memory read per
//  rule and stops at the first match or after the last stored rule.
//  Reset clears the state, the rule count and the valid flags; memory
//  entries are never read before they are written. A new word is accepted
//  while a result waits on m_.
// ============================================================================
`default_nettype none

module first_match_packet_rule_classifier
    import fmprc_pkg::*;
#(
    parameter int RULE_SLOTS = FMPRC_RULE_SLOTS
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire in_word_t s_word,
    output logic       m_valid,
    input  wire        m_ready,
    output out_word_t  m_word
);

    localparam int IDX_W = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W = $clog2(RULE_SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    rule_addr_t   addr_mem   [RULE_SLOTS];
    rule_fields_t fields_mem [RULE_SLOTS];

    logic [1:0]       state_reg,     state_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic [CNT_W-1:0] rd_idx_reg,    rd_idx_next;
    logic [CNT_W-1:0] cmp_idx_reg,   cmp_idx_next;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             m_valid_reg,   m_valid_next;
    in_word_t         item_reg,      item_next;
    out_word_t        res_reg,       res_next;
    out_word_t        m_word_reg,    m_word_next;
    rule_addr_t       rd_addr_reg;
    rule_fields_t     rd_fields_reg;

    logic s_accept;
    logic wr_en;
    logic rd_issue;
    logic match;
    logic is_full;
    logic out_free;
    logic is_xmas;
    logic is_irrelevant;

    fmprc_rule_match u_match (
        .pkt         (item_reg),
        .rule_addr   (rd_addr_reg),
        .rule_fields (rd_fields_reg),
        .match       (match)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign is_full       = (count_reg >= CNT_W'(RULE_SLOTS));
    assign wr_en         = s_accept && (s_word.operation == OP_ADD) && !is_full;
    assign rd_issue      = (state_reg == ST_SCAN) && (rd_idx_reg < count_reg);
    assign is_xmas       = (s_word.protocol == PROTO_TCP) && (s_word.tcp_flags == XMAS_FLAGS);
    assign is_irrelevant = ((s_word.protocol != PROTO_TCP) &&
                            (s_word.protocol != PROTO_UDP) &&
                            (s_word.protocol != PROTO_ICMP)) ||
                           (s_word.ip_version == IP_VERSION_6);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            addr_mem[count_reg[IDX_W-1:0]]   <= '{src_addr: s_word.src_addr,
                                                  dst_addr: s_word.dst_addr};
            fields_mem[count_reg[IDX_W-1:0]] <= '{action:         s_word.rule_action,
                                                  ack_mode:       s_word.ack_mode,
                                                  protocol:       s_word.protocol,
                                                  dport:          s_word.dport,
                                                  sport:          s_word.sport,
                                                  dst_prefix_len: s_word.dst_prefix_len,
                                                  src_prefix_len: s_word.src_prefix_len};
        end
        if (rd_issue) begin
            rd_addr_reg   <= addr_mem[rd_idx_reg[IDX_W-1:0]];
            rd_fields_reg <= fields_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    always_comb begin
        logic [CNT_W+6:0] cnt_ext;
        logic [CNT_W+5:0] hit_ext;

        state_next     = state_reg;
        count_next     = count_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        cmp_valid_next = 1'b0;
        m_valid_next   = m_valid_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        m_word_next    = m_word_reg;
        cnt_ext        = '0;
        hit_ext        = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    item_next                = s_word;
                    res_next.verdict         = 1'b0;
                    res_next.decision_cause  = CAUSE_NONE;
                    res_next.hit_index       = 6'd0;
                    res_next.table_full      = 1'b0;
                    state_next               = ST_EMIT;
                    case (s_word.operation)
                        OP_CLEAR: begin
                            count_next = '0;
                        end
                        OP_ADD: begin
                            if (is_full) begin
                                res_next.table_full = 1'b1;
                            end else begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_CLASSIFY: begin
                            if (is_xmas) begin
                                res_next.verdict        = 1'b1;
                                res_next.decision_cause = CAUSE_XMAS;
                            end else if (is_irrelevant) begin
                                res_next.decision_cause = CAUSE_IRRELEVANT;
                            end else begin
                                res_next.verdict        = 1'b1;
                                res_next.decision_cause = CAUSE_DEFAULT;
                                if (count_reg != '0) begin
                                    rd_idx_next = '0;
                                    state_next  = ST_SCAN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    cnt_ext                = {7'd0, count_next};
                    res_next.stored_count  = cnt_ext[6:0];
                end
            end
            ST_SCAN: begin
                if (rd_issue) begin
                    rd_idx_next    = rd_idx_reg + 1'b1;
                    cmp_idx_next   = rd_idx_reg;
                    cmp_valid_next = 1'b1;
                end
                if (cmp_valid_reg && match) begin
                    hit_ext                 = {6'd0, cmp_idx_reg};
                    res_next.verdict        = rd_fields_reg.action;
                    res_next.decision_cause = CAUSE_HIT;
                    res_next.hit_index      = hit_ext[5:0];
                    cmp_valid_next          = 1'b0;
                    state_next              = ST_EMIT;
                end else if (cmp_valid_reg && (rd_idx_reg == count_reg)) begin
                    cmp_valid_next = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_word_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        rd_idx_reg  <= rd_idx_next;
        cmp_idx_reg <= cmp_idx_next;
        item_reg    <= item_next;
        res_reg     <= res_next;
        m_word_reg  <= m_word_next;
    end

endmodule

`default_nettype wire
